@@ rtl/core/mah_pkg.sv @@
// mah_pkg: shared types and constants for the moving average alarm block
// no dependencies; used by mah_ifs.sv and moving_average_hysteresis_alarm.sv

package mah_pkg;

	// default build values
	localparam int WINDOW_DEF      = 4;
	localparam int SAMPLE_BITS_DEF = 16;

	// threshold registers
	localparam int THR_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic signed [THR_W-1:0] WARN_RISE_RST  = 16'sd960;
	localparam logic signed [THR_W-1:0] ALARM_RISE_RST = 16'sd1280;
	localparam logic signed [THR_W-1:0] ALARM_FALL_RST = 16'sd1120;
	localparam logic signed [THR_W-1:0] WARN_FALL_RST  = 16'sd800;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WARN_RISE  = 2'd0,
		CFG_ALARM_RISE = 2'd1,
		CFG_ALARM_FALL = 2'd2,
		CFG_WARN_FALL  = 2'd3
	} cfg_idx_t;

	// alarm level and transition codes
	typedef enum logic [1:0] {
		LVL_NORMAL  = 2'd0,
		LVL_WARNING = 2'd1,
		LVL_ALARM   = 2'd2
	} level_t;

	typedef enum logic [1:0] {
		TR_NONE      = 2'd0,
		TR_ESCALATED = 2'd1,
		TR_RECOVERED = 2'd2
	} trans_t;

	// sequencer steps
	typedef enum logic [3:0] {
		S_IDLE,
		S_EVICT,
		S_ADD,
		S_ABS,
		S_DIV,
		S_SIGN,
		S_MUL1,
		S_CMP1,
		S_MUL2,
		S_CMP2,
		S_DONE
	} state_t;

endpackage

@@ rtl/core/mah_ifs.sv @@
// mah_ifs: valid/ready channels of the moving average alarm block
// depends on mah_pkg for default widths

interface mah_sample_if #(parameter int SAMPLE_BITS = mah_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample;

	modport source(output valid, sample, input ready);
	modport sink(input valid, sample, output ready);
endinterface

interface mah_result_if #(parameter int SAMPLE_BITS = mah_pkg::SAMPLE_BITS_DEF);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] average;
	logic [1:0]                    level;
	logic [1:0]                    transition;

	modport source(output valid, average, level, transition, input ready);
	modport sink(input valid, average, level, transition, output ready);
endinterface

interface mah_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [mah_pkg::CFG_IDX_W-1:0]        index;
	logic signed [mah_pkg::THR_W-1:0]     wdata;

	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

@@ rtl/core/moving_average_hysteresis_alarm.sv @@
// moving_average_hysteresis_alarm: windowed mean of sensor samples with a
// three-level hysteresis alarm; depends on mah_pkg and mah_ifs
//
//   channel   dir   transfer carries
//   samples   in    sample
//   results   out   average, level, transition
//   cfg       in    index, wdata (threshold register write)
//
// the restoring divider works out one quotient bit a cycle through the shared
// adder. samples.ready is high only when the sequencer is idle, so the next
// sample can be taken at the earliest in the cycle after the result is loaded.
// a finished result waits in the output register while the next sample is
// taken; a result still waiting at the end of the following sample holds the
// sequencer. reset clears the ring pointers, sum and level and loads the
// thresholds with their defaults; the ring memory itself needs no clearing.

module moving_average_hysteresis_alarm #(
	parameter int WINDOW      = mah_pkg::WINDOW_DEF,
	parameter int SAMPLE_BITS = mah_pkg::SAMPLE_BITS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	mah_sample_if.sink   samples,
	mah_result_if.source results,
	mah_cfg_if.sink      cfg
);
	import mah_pkg::*;

	localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int SUM_W = SAMPLE_BITS + CNT_W;
	localparam int DW    = SUM_W;
	localparam int DCW   = $clog2(DW);
	localparam int PW    = THR_W + CNT_W + 1;
	localparam int AW    = ((SUM_W > PW) ? SUM_W : PW) + 1;

	// ring memory
	logic [SAMPLE_BITS-1:0] mem [WINDOW];
	logic [SAMPLE_BITS-1:0] rd_q;

	// control and datapath registers
	state_t                    state_q, state_d;
	logic [POS_W-1:0]          wpos_q;
	logic [CNT_W-1:0]          cnt_q;
	logic [SUM_W-1:0]          sum_q;
	logic [SAMPLE_BITS-1:0]    x_q;
	logic [DW-1:0]             quo_q;
	logic [CNT_W:0]            rem_q;
	logic [DCW-1:0]            dcnt_q;
	logic                      neg_q;
	logic [SAMPLE_BITS-1:0]    avg_q;
	logic signed [AW-1:0]      prod_q;
	level_t                    lvl_q, nlvl_q;
	logic signed [THR_W-1:0]   warn_rise_q, alarm_rise_q, alarm_fall_q, warn_fall_q;

	// output register
	logic                      ov_q;
	logic [SAMPLE_BITS-1:0]    avg_o_q;
	level_t                    lvl_o_q;
	trans_t                    tr_o_q;

	// shared adder
	logic [AW-1:0]             alu_a, alu_b, alu_res;
	logic                      alu_sub;
	logic signed [THR_W-1:0]   thr_sel;
	logic                      full, acc_in, out_free, ge, le;
	logic [AW-1:0]             sum_ext, quo_ext, cnt_ext;
	logic [CNT_W+1:0]          trial_a;
	logic signed [AW-1:0]      thr_ext, cnt_s;
	trans_t                    tr_d;

	assign full     = (cnt_q == CNT_W'(WINDOW));
	assign acc_in   = samples.valid && samples.ready;
	assign out_free = !ov_q || results.ready;
	assign sum_ext  = {{(AW-SUM_W){sum_q[SUM_W-1]}}, sum_q};
	assign quo_ext  = AW'(quo_q);
	assign cnt_ext  = AW'(cnt_q);
	assign trial_a  = {rem_q, quo_q[DW-1]};
	assign alu_res  = alu_a + (alu_b ^ {AW{alu_sub}}) + AW'(alu_sub);
	assign ge       = !alu_res[AW-1];
	assign le       = alu_res[AW-1] || (alu_res == '0);
	assign thr_ext  = {{(AW-THR_W){thr_sel[THR_W-1]}}, thr_sel};
	assign cnt_s    = $signed(cnt_ext);
	assign cfg.ready = 1'b1;

	// next step of the sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (acc_in) state_d = S_EVICT;
			S_EVICT: state_d = S_ADD;
			S_ADD:   state_d = S_ABS;
			S_ABS:   state_d = S_DIV;
			S_DIV:   if (dcnt_q == '0) state_d = S_SIGN;
			S_SIGN:  state_d = S_MUL1;
			S_MUL1:  state_d = S_CMP1;
			S_CMP1:  state_d = (lvl_q == LVL_WARNING && !ge) ? S_MUL2 : S_DONE;
			S_MUL2:  state_d = S_CMP2;
			S_CMP2:  state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// operand selection and handshake outputs
	always_comb begin
		samples.ready = (state_q == S_IDLE);
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		thr_sel = warn_fall_q;
		unique case (state_q)
			S_EVICT: begin
				alu_a   = sum_ext;
				alu_b   = {{(AW-SAMPLE_BITS){rd_q[SAMPLE_BITS-1]}}, rd_q};
				alu_sub = 1'b1;
			end
			S_ADD: begin
				alu_a = sum_ext;
				alu_b = {{(AW-SAMPLE_BITS){x_q[SAMPLE_BITS-1]}}, x_q};
			end
			S_ABS: begin
				alu_sub = sum_q[SUM_W-1];
				alu_a   = alu_sub ? '0 : sum_ext;
				alu_b   = alu_sub ? sum_ext : '0;
			end
			S_DIV: begin
				alu_a   = AW'(trial_a);
				alu_b   = cnt_ext;
				alu_sub = 1'b1;
			end
			S_SIGN: begin
				alu_sub = neg_q;
				alu_a   = neg_q ? '0 : quo_ext;
				alu_b   = neg_q ? quo_ext : '0;
			end
			S_MUL1: begin
				priority case (lvl_q)
					LVL_NORMAL:  thr_sel = warn_rise_q;
					LVL_WARNING: thr_sel = alarm_rise_q;
					default:     thr_sel = alarm_fall_q;
				endcase
			end
			S_CMP1, S_CMP2: begin
				alu_a   = sum_ext;
				alu_b   = prod_q;
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// transition code from old and new level
	always_comb begin
		if (nlvl_q > lvl_q) begin
			tr_d = TR_ESCALATED;
		end else if (nlvl_q < lvl_q) begin
			tr_d = TR_RECOVERED;
		end else begin
			tr_d = TR_NONE;
		end
	end

	// ring memory write and registered read
	always_ff @(posedge clk) begin
		if (acc_in) begin
			rd_q <= mem[wpos_q];
		end
		if (state_q == S_EVICT) begin
			mem[wpos_q] <= x_q;
		end
	end

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warn_rise_q  <= WARN_RISE_RST;
			alarm_rise_q <= ALARM_RISE_RST;
			alarm_fall_q <= ALARM_FALL_RST;
			warn_fall_q  <= WARN_FALL_RST;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_idx_t'(cfg.index))
				CFG_WARN_RISE:  warn_rise_q  <= cfg.wdata;
				CFG_ALARM_RISE: alarm_rise_q <= cfg.wdata;
				CFG_ALARM_FALL: alarm_fall_q <= cfg.wdata;
				CFG_WARN_FALL:  warn_fall_q  <= cfg.wdata;
			endcase
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wpos_q  <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			lvl_q   <= LVL_NORMAL;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			// output register fills at the end of a sample, empties on a transfer
			if (state_q == S_DONE && out_free) begin
				ov_q <= 1'b1;
			end else if (results.valid && results.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_EVICT: begin
					if (full) begin
						sum_q <= alu_res[SUM_W-1:0];
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
					wpos_q <= (wpos_q == POS_W'(WINDOW - 1)) ? '0 : wpos_q + POS_W'(1);
				end
				S_ADD: begin
					sum_q <= alu_res[SUM_W-1:0];
				end
				S_DONE: begin
					if (out_free) begin
						lvl_q <= nlvl_q;
					end
				end
				default: begin
					lvl_q <= lvl_q;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (acc_in) begin
			x_q <= samples.sample;
		end
		unique case (state_q)
			S_ABS: begin
				quo_q  <= alu_res[DW-1:0];
				neg_q  <= sum_q[SUM_W-1];
				rem_q  <= '0;
				dcnt_q <= DCW'(DW - 1);
			end
			S_DIV: begin
				// restoring step: keep the difference when it stays non-negative
				if (ge) begin
					rem_q <= alu_res[CNT_W:0];
				end else begin
					rem_q <= trial_a[CNT_W:0];
				end
				quo_q  <= {quo_q[DW-2:0], ge};
				dcnt_q <= dcnt_q - DCW'(1);
			end
			S_SIGN: begin
				avg_q <= alu_res[SAMPLE_BITS-1:0];
			end
			S_MUL1, S_MUL2: begin
				prod_q <= thr_ext * cnt_s;
			end
			S_CMP1: begin
				priority case (lvl_q)
					LVL_NORMAL:  nlvl_q <= ge ? LVL_WARNING : LVL_NORMAL;
					LVL_WARNING: nlvl_q <= ge ? LVL_ALARM : LVL_WARNING;
					LVL_ALARM:   nlvl_q <= le ? LVL_WARNING : LVL_ALARM;
					default:     nlvl_q <= lvl_q;
				endcase
			end
			S_CMP2: begin
				nlvl_q <= le ? LVL_NORMAL : LVL_WARNING;
			end
			S_DONE: begin
				if (out_free) begin
					avg_o_q <= avg_q;
					lvl_o_q <= nlvl_q;
					tr_o_q  <= tr_d;
				end
			end
			default: begin
				avg_o_q <= avg_o_q;
			end
		endcase
	end

	// result channel
	assign results.valid      = ov_q;
	assign results.average    = avg_o_q;
	assign results.level      = lvl_o_q;
	assign results.transition = tr_o_q;

endmodule
